// ===== hw/rtl/krt_pkg.sv =====
// krt_pkg: shared types and codes for the keyed record table
// item structs for the command and result sides, command and status codes
`timescale 1ns / 1ps

package krt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int WORD_W       = 32;
    localparam int ROW_WORDS    = 8;

    // command codes
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_EXISTS = 3'd3;
    localparam logic [2:0] CMD_LIST   = 3'd4;

    // status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_EMPTY     = 2'd3;

    // word positions inside one stored row
    localparam int W_KEY      = 0;
    localparam int W_YEAR     = 1;
    localparam int W_COURSE_A = 2;
    localparam int W_GRADE_A  = 3;
    localparam int W_COURSE_B = 4;
    localparam int W_GRADE_B  = 5;
    localparam int W_COURSE_C = 6;
    localparam int W_GRADE_C  = 7;

    typedef logic [ROW_WORDS-1:0][WORD_W-1:0] t_row;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] year_in;
        logic [WORD_W-1:0] course_a_in;
        logic [WORD_W-1:0] grade_a_in;
        logic [WORD_W-1:0] course_b_in;
        logic [WORD_W-1:0] grade_b_in;
        logic [WORD_W-1:0] course_c_in;
        logic [WORD_W-1:0] grade_c_in;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [4:0]        used_count;
        logic [WORD_W-1:0] key_out;
        logic [WORD_W-1:0] year_out;
        logic [WORD_W-1:0] course_a_out;
        logic [WORD_W-1:0] grade_a_out;
        logic [WORD_W-1:0] course_b_out;
        logic [WORD_W-1:0] grade_b_out;
        logic [WORD_W-1:0] course_c_out;
        logic [WORD_W-1:0] grade_c_out;
        logic              last;
    } t_result_item;

endpackage

// ===== hw/rtl/keyed_record_table.sv =====
// keyed_record_table: fixed-capacity record table with linear key search
// depends on krt_pkg for item structs, command and status codes
`timescale 1ns / 1ps

// usage
// - command side: drive i_item and raise start; the item is taken at an edge
//   where start is high and busy is low. busy stays high while a search,
//   a delete compaction or a listing walks the table
// - result side: o_valid marks one result item for exactly one cycle; the
//   receiver cannot stall, so every result must be taken when shown
// - add, empty read/delete/exists and empty list finish at the accept edge;
//   their result shows in the next cycle and the next item may follow right
//   away. an unknown command is dropped at the accept edge with no result
// - read and exists: one row read per cycle from the record memory through
//   one key comparator
// - delete: the search, then every row above the hit is shifted down in
//   turn (read one row, write the next lower one)
// - list: one key per cycle, min(used, 16) results, last one flagged
// - the final result of a command shows in the first cycle with busy low;
//   the table is walked through the single read port of the record memory
// - reset: synchronous, active low; the table becomes empty. row contents
//   are not cleared, only rows below the fill count are ever read
module keyed_record_table
    import krt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    input  t_cmd_item    i_item,
    output logic         busy,
    output logic         o_valid,
    output t_result_item o_item
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int EXT_W = CNT_W + 5;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_LIST  = 2'd3;

    // record memory, one row per entry, registered read
    t_row r_mem [CAPACITY];
    t_row r_rd_data;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_fill,  n_fill;
    logic [CNT_W-1:0]  r_idx,   n_idx;     // next row to fetch
    logic [CNT_W-1:0]  r_lim,   n_lim;     // rows to walk
    logic              r_pend,  n_pend;    // r_rd_data holds row r_pidx
    logic [IDX_W-1:0]  r_pidx,  n_pidx;
    logic [2:0]        r_cmd,   n_cmd;
    logic [WORD_W-1:0] r_key,   n_key;
    logic              r_valid, n_valid;
    t_result_item      r_out,   n_out;

    logic              mem_re;
    logic              mem_we;
    logic [IDX_W-1:0]  raddr;
    logic [IDX_W-1:0]  waddr;
    t_row              wdata;
    logic              hit;
    logic              more;
    logic              full;
    logic              list_last;
    logic [CNT_W-1:0]  list_lim;

    assign hit       = r_pend && (r_rd_data[W_KEY] == r_key);
    assign more      = r_idx < r_lim;
    assign full      = r_fill >= CNT_W'(CAPACITY);
    assign list_last = (CNT_W'(r_pidx) + CNT_W'(1)) == r_lim;
    // listing stops after the result limit when the table is larger
    assign list_lim  = (EXT_W'(r_fill) > EXT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : r_fill;

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_idx   = r_idx;
        n_lim   = r_lim;
        n_pend  = 1'b0;
        n_pidx  = r_pidx;
        n_cmd   = r_cmd;
        n_key   = r_key;
        n_valid = 1'b0;
        n_out   = r_out;
        mem_re  = 1'b0;
        mem_we  = 1'b0;
        raddr   = r_idx[IDX_W-1:0];
        waddr   = r_fill[IDX_W-1:0];
        wdata   = {i_item.grade_c_in, i_item.course_c_in, i_item.grade_b_in,
                   i_item.course_b_in, i_item.grade_a_in, i_item.course_a_in,
                   i_item.year_in, i_item.key};

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd = i_item.cmd;
                    n_key = i_item.key;
                    n_idx = '0;
                    unique case (i_item.cmd)
                        CMD_ADD: begin
                            n_valid = 1'b1;
                            n_out   = '0;
                            n_out.last = 1'b1;
                            if (full) begin
                                n_out.status     = STS_FULL;
                                n_out.used_count = 5'(r_fill);
                            end else begin
                                // append at the fill position
                                mem_we = 1'b1;
                                n_fill = r_fill + CNT_W'(1);
                                n_out.status     = STS_OK;
                                n_out.used_count = 5'(n_fill);
                            end
                        end
                        CMD_READ, CMD_DELETE, CMD_EXISTS: begin
                            if (r_fill == '0) begin
                                n_valid = 1'b1;
                                n_out   = '0;
                                n_out.status     = STS_NOT_FOUND;
                                n_out.used_count = 5'(r_fill);
                                n_out.last       = 1'b1;
                            end else begin
                                n_lim   = r_fill;
                                n_state = ST_SCAN;
                            end
                        end
                        CMD_LIST: begin
                            if (r_fill == '0) begin
                                n_valid = 1'b1;
                                n_out   = '0;
                                n_out.status     = STS_EMPTY;
                                n_out.used_count = 5'(r_fill);
                                n_out.last       = 1'b1;
                            end else begin
                                n_lim   = list_lim;
                                n_state = ST_LIST;
                            end
                        end
                        default: begin
                            // unknown command: dropped without a result
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (hit) begin
                    unique case (r_cmd)
                        CMD_READ: begin
                            n_valid = 1'b1;
                            n_out   = '0;
                            n_out.status       = STS_OK;
                            n_out.used_count   = 5'(r_fill);
                            n_out.key_out      = r_rd_data[W_KEY];
                            n_out.year_out     = r_rd_data[W_YEAR];
                            n_out.course_a_out = r_rd_data[W_COURSE_A];
                            n_out.grade_a_out  = r_rd_data[W_GRADE_A];
                            n_out.course_b_out = r_rd_data[W_COURSE_B];
                            n_out.grade_b_out  = r_rd_data[W_GRADE_B];
                            n_out.course_c_out = r_rd_data[W_COURSE_C];
                            n_out.grade_c_out  = r_rd_data[W_GRADE_C];
                            n_out.last         = 1'b1;
                            n_state = ST_IDLE;
                        end
                        CMD_EXISTS: begin
                            n_valid = 1'b1;
                            n_out   = '0;
                            n_out.status     = STS_OK;
                            n_out.used_count = 5'(r_fill);
                            n_out.last       = 1'b1;
                            n_state = ST_IDLE;
                        end
                        default: begin
                            // delete: move every row above the hit down one
                            n_idx   = CNT_W'(r_pidx) + CNT_W'(1);
                            n_state = ST_SHIFT;
                        end
                    endcase
                end else if (more) begin
                    mem_re = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + CNT_W'(1);
                end else begin
                    n_valid = 1'b1;
                    n_out   = '0;
                    n_out.status     = STS_NOT_FOUND;
                    n_out.used_count = 5'(r_fill);
                    n_out.last       = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            ST_SHIFT: begin
                if (r_pend) begin
                    mem_we = 1'b1;
                    waddr  = r_pidx - IDX_W'(1);
                    wdata  = r_rd_data;
                end
                if (more) begin
                    mem_re = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + CNT_W'(1);
                end else begin
                    n_fill  = r_fill - CNT_W'(1);
                    n_valid = 1'b1;
                    n_out   = '0;
                    n_out.status     = STS_OK;
                    n_out.used_count = 5'(n_fill);
                    n_out.last       = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            ST_LIST: begin
                if (r_pend) begin
                    n_valid = 1'b1;
                    n_out   = '0;
                    n_out.status     = STS_OK;
                    n_out.used_count = 5'(r_fill);
                    n_out.key_out    = r_rd_data[W_KEY];
                    n_out.last       = list_last;
                    if (list_last) begin
                        n_state = ST_IDLE;
                    end
                end
                if (more) begin
                    mem_re = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + CNT_W'(1);
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // record memory ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_lim  <= n_lim;
        r_pidx <= n_pidx;
        r_cmd  <= n_cmd;
        r_key  <= n_key;
        r_out  <= n_out;
    end

    assign busy    = r_state != ST_IDLE;
    assign o_valid = r_valid;
    assign o_item  = r_out;

endmodule

// ===== tb/sv/keyed_record_table_tb.sv =====
// keyed_record_table_tb: self-checking testbench for the keyed record table
// drives command items, predicts every result item and compares field by field
// depends on krt_pkg and keyed_record_table
`timescale 1ns / 1ps

module keyed_record_table_tb;
    import krt_pkg::*;

    localparam int N_ROWS       = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 380;
    localparam int TAIL_ITEMS   = 80;     // last stretch runs without idling
    localparam int PHASE_ITEMS  = 40;     // length of an add-heavy or delete-heavy phase
    localparam int DRAIN_EVERY  = 60;
    localparam int DRAIN_CYCLES = 40;     // longer than the longest command
    localparam int CYCLE_LIMIT  = 300000;
    localparam int POOL_SIZE    = 8;

    // codes the block must drop without a result
    localparam logic [2:0] CMD_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNKNOWN_LAST  = 3'd7;

    localparam logic [WORD_W-1:0] DUP_KEY = 32'h0000_0A0A;

    logic         i_clk;
    logic         i_rst_n;
    logic         start;
    t_cmd_item    i_item;
    logic         busy;
    logic         o_valid;
    t_result_item o_item;

    // shadow copy of the table
    t_row         model_rows [N_ROWS];
    int           model_fill;
    t_result_item due_results [$];

    int           accept_count;
    int           mismatch_count;
    int           cycle_count;
    bit           idle_on;
    logic [WORD_W-1:0] key_pool [POOL_SIZE];

    keyed_record_table #(
        .CAPACITY(N_ROWS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_item (i_item),
        .busy   (busy),
        .o_valid(o_valid),
        .o_item (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // table model
    // ---------------------------------------------------------------

    // first row from index 0 up whose key matches, or -1
    function automatic int find_first_key(logic [WORD_W-1:0] key);
        int i;
        for (i = 0; i < model_fill; i++)
            if (model_rows[i][W_KEY] == key)
                return i;
        return -1;
    endfunction

    // single-result item with zeroed data words and the current fill
    function automatic t_result_item status_only(logic [1:0] status);
        t_result_item res;
        res            = '0;
        res.status     = status;
        res.used_count = 5'(model_fill);
        res.last       = 1'b1;
        return res;
    endfunction

    // applies one accepted command and queues the results it owes
    function automatic void apply_record_cmd(t_cmd_item it);
        t_result_item res;
        t_row         row;
        int           hit;
        int           n;
        int           i;
        case (it.cmd)
            CMD_ADD: begin
                if (model_fill >= N_ROWS) begin
                    due_results.push_back(status_only(STS_FULL));
                end else begin
                    row[W_KEY]      = it.key;
                    row[W_YEAR]     = it.year_in;
                    row[W_COURSE_A] = it.course_a_in;
                    row[W_GRADE_A]  = it.grade_a_in;
                    row[W_COURSE_B] = it.course_b_in;
                    row[W_GRADE_B]  = it.grade_b_in;
                    row[W_COURSE_C] = it.course_c_in;
                    row[W_GRADE_C]  = it.grade_c_in;
                    model_rows[model_fill] = row;
                    model_fill++;
                    due_results.push_back(status_only(STS_OK));
                end
            end
            CMD_READ: begin
                hit = find_first_key(it.key);
                if (hit < 0) begin
                    due_results.push_back(status_only(STS_NOT_FOUND));
                end else begin
                    row              = model_rows[hit];
                    res              = status_only(STS_OK);
                    res.key_out      = row[W_KEY];
                    res.year_out     = row[W_YEAR];
                    res.course_a_out = row[W_COURSE_A];
                    res.grade_a_out  = row[W_GRADE_A];
                    res.course_b_out = row[W_COURSE_B];
                    res.grade_b_out  = row[W_GRADE_B];
                    res.course_c_out = row[W_COURSE_C];
                    res.grade_c_out  = row[W_GRADE_C];
                    due_results.push_back(res);
                end
            end
            CMD_DELETE: begin
                hit = find_first_key(it.key);
                if (hit < 0) begin
                    due_results.push_back(status_only(STS_NOT_FOUND));
                end else begin
                    // close the gap, later rows move down one place
                    for (i = hit; i < model_fill - 1; i++)
                        model_rows[i] = model_rows[i + 1];
                    model_fill--;
                    due_results.push_back(status_only(STS_OK));
                end
            end
            CMD_EXISTS: begin
                hit = find_first_key(it.key);
                due_results.push_back(status_only(hit < 0 ? STS_NOT_FOUND : STS_OK));
            end
            CMD_LIST: begin
                if (model_fill == 0) begin
                    due_results.push_back(status_only(STS_EMPTY));
                end else begin
                    n = (model_fill < MAX_RESULTS) ? model_fill : MAX_RESULTS;
                    for (i = 0; i < n; i++) begin
                        res         = status_only(STS_OK);
                        res.key_out = model_rows[i][W_KEY];
                        res.last    = (i == n - 1);
                        due_results.push_back(res);
                    end
                end
            end
            default: begin
                // unknown command: dropped, no result
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic flag_mismatch(string what, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
        $display("t=%0t result mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic compare_result(t_result_item got, t_result_item want);
        if (got.status !== want.status)
            flag_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
        if (got.used_count !== want.used_count)
            flag_mismatch("used_count", WORD_W'(got.used_count), WORD_W'(want.used_count));
        if (got.key_out !== want.key_out)
            flag_mismatch("key_out", got.key_out, want.key_out);
        if (got.year_out !== want.year_out)
            flag_mismatch("year_out", got.year_out, want.year_out);
        if (got.course_a_out !== want.course_a_out)
            flag_mismatch("course_a_out", got.course_a_out, want.course_a_out);
        if (got.grade_a_out !== want.grade_a_out)
            flag_mismatch("grade_a_out", got.grade_a_out, want.grade_a_out);
        if (got.course_b_out !== want.course_b_out)
            flag_mismatch("course_b_out", got.course_b_out, want.course_b_out);
        if (got.grade_b_out !== want.grade_b_out)
            flag_mismatch("grade_b_out", got.grade_b_out, want.grade_b_out);
        if (got.course_c_out !== want.course_c_out)
            flag_mismatch("course_c_out", got.course_c_out, want.course_c_out);
        if (got.grade_c_out !== want.grade_c_out)
            flag_mismatch("grade_c_out", got.grade_c_out, want.grade_c_out);
        if (got.last !== want.last)
            flag_mismatch("last", WORD_W'(got.last), WORD_W'(want.last));
    endtask

    // pre-edge values are seen here, the block updates after this block runs
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (due_results.size() == 0)
                flag_mismatch("result with none due, key_out", o_item.key_out, '0);
            else
                compare_result(o_item, due_results.pop_front());
        end
        // command taken at this edge: predict before any result can show
        if (i_rst_n && start && busy === 1'b0) begin
            apply_record_cmd(i_item);
            accept_count++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers, all called at a falling edge
    // ---------------------------------------------------------------

    // command with random value words
    function automatic t_cmd_item make_item(logic [2:0] cmd, logic [WORD_W-1:0] key);
        t_cmd_item it;
        it.cmd         = cmd;
        it.key         = key;
        it.year_in     = $urandom;
        it.course_a_in = $urandom;
        it.grade_a_in  = $urandom;
        it.course_b_in = $urandom;
        it.grade_b_in  = $urandom;
        it.course_c_in = $urandom;
        it.grade_c_in  = $urandom;
        return it;
    endfunction

    // offers one item and returns at the falling edge after it was taken;
    // start stays high so a following item goes back to back
    task automatic send_cmd(t_cmd_item it);
        int taken;
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        taken = accept_count;
        start  <= 1'b1;
        i_item <= it;
        do @(negedge i_clk); while (accept_count == taken);
    endtask

    // sender holds off until every owed result has come back
    task automatic hold_until_drained;
        start <= 1'b0;
        @(negedge i_clk);
        while (due_results.size() != 0) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // empty table: misses, empty listing, dropped unknown codes
    task automatic test_empty_table;
        t_cmd_item it;
        int        c;
        send_cmd(make_item(CMD_READ, '0));
        send_cmd(make_item(CMD_DELETE, '1));
        send_cmd(make_item(CMD_EXISTS, $urandom));
        send_cmd(make_item(CMD_LIST, $urandom));
        for (c = CMD_UNKNOWN_FIRST; c <= CMD_UNKNOWN_LAST; c++) begin
            it     = '1;
            it.cmd = 3'(c);
            send_cmd(it);
        end
    endtask

    // fill to capacity with extreme rows and a duplicated key, then overflow,
    // list, and check that read and delete hit the first duplicate
    task automatic test_fill_and_full;
        t_cmd_item it;
        int        i;
        for (i = 0; i < N_ROWS; i++) begin
            case (i)
                0: begin
                    it     = '0;
                    it.cmd = CMD_ADD;
                end
                1: begin
                    it     = '1;
                    it.cmd = CMD_ADD;
                end
                2, 5: it = make_item(CMD_ADD, DUP_KEY);
                default: it = make_item(CMD_ADD, $urandom);
            endcase
            send_cmd(it);
        end
        // add on a full table, all fields at their top
        it     = '1;
        it.cmd = CMD_ADD;
        send_cmd(it);
        send_cmd(make_item(CMD_LIST, '0));
        send_cmd(make_item(CMD_READ, DUP_KEY));
        send_cmd(make_item(CMD_DELETE, DUP_KEY));
        send_cmd(make_item(CMD_READ, DUP_KEY));
        send_cmd(make_item(CMD_EXISTS, '1));
        send_cmd(make_item(CMD_DELETE, '0));
    endtask

    // long mixed run; keys mostly from a small pool so hits and duplicates
    // are common, phases alternate between filling and emptying the table
    task automatic test_random_traffic;
        t_cmd_item         it;
        logic [2:0]        cmd;
        logic [WORD_W-1:0] key;
        int                sent;
        int                pick;
        int                i;
        bit                filling;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_on = (sent < RANDOM_ITEMS - TAIL_ITEMS);
            // pauses only outside the gap-free tail
            if (idle_on && sent % DRAIN_EVERY == DRAIN_EVERY - 1)
                hold_until_drained();
            filling = ((sent / PHASE_ITEMS) % 2 == 0);
            pick    = $urandom_range(0, 99);
            if (filling) begin
                if      (pick < 50) cmd = CMD_ADD;
                else if (pick < 62) cmd = CMD_READ;
                else if (pick < 72) cmd = CMD_DELETE;
                else if (pick < 82) cmd = CMD_EXISTS;
                else if (pick < 94) cmd = CMD_LIST;
                else                cmd = 3'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
            end else begin
                if      (pick < 15) cmd = CMD_ADD;
                else if (pick < 35) cmd = CMD_READ;
                else if (pick < 70) cmd = CMD_DELETE;
                else if (pick < 80) cmd = CMD_EXISTS;
                else if (pick < 94) cmd = CMD_LIST;
                else                cmd = 3'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
            end
            if ($urandom_range(0, 4) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            it = make_item(cmd, key);
            send_cmd(it);
            // dropped codes do not count toward the run length
            if (cmd < CMD_UNKNOWN_FIRST)
                sent++;
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_item         = '0;
        model_fill     = 0;
        accept_count   = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        idle_on        = 1'b1;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_fill_and_full();
        hold_until_drained();
        test_random_traffic();

        // wait out the owed results, then a quiet stretch for strays
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (due_results.size() != 0)
            flag_mismatch("results never delivered, count", due_results.size(), '0);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
